// File: sv/qidd_pkg.sv
// shared types and constants for the quadrature integrate-and-dump demodulator
`timescale 1ns / 1ps

package qidd_pkg;

  localparam int SampleBits = 10;
  localparam int SumW       = 28;
  localparam int SqW        = SumW - 3;
  localparam int AccW       = 2 * SqW;
  localparam int EnW        = AccW - 8;
  localparam int MagW       = 22;
  localparam int DrvW       = 16;
  localparam int LenW       = 16;
  localparam int ShiftW     = 5;
  localparam int HalfW      = 5;
  localparam int CfgAddrW   = 2;
  localparam int CfgDataW   = 16;
  localparam int InTdataW   = ((SampleBits + 7) / 8) * 8;
  localparam int OutFieldW  = 2 * SumW + MagW + DrvW;
  localparam int OutTdataW  = ((OutFieldW + 7) / 8) * 8;

  localparam int GroupQuad  = 4;
  localparam int GroupTwo   = 2;

  localparam logic [CfgAddrW-1:0] RegQuadMode  = 2'd0;
  localparam logic [CfgAddrW-1:0] RegFrameLen  = 2'd1;
  localparam logic [CfgAddrW-1:0] RegPwmTop    = 2'd2;
  localparam logic [CfgAddrW-1:0] RegDriveShft = 2'd3;

  localparam logic [LenW-1:0]   FrameLenRst   = 16'd1000;
  localparam logic [DrvW-1:0]   PwmTopRst     = 16'd27;
  localparam logic [ShiftW-1:0] DriveShiftRst = 5'd7;

  typedef struct packed {
    logic              quad;
    logic [LenW-1:0]   frame_len;
    logic [DrvW-1:0]   pwm_top;
    logic [ShiftW-1:0] drive_shift;
  } cfg_t;

  typedef struct packed {
    logic                   valid;
    logic                   quad;
    logic signed [SumW-1:0] i_sum;
    logic signed [SumW-1:0] q_sum;
  } frame_t;

  typedef struct packed {
    logic [DrvW-1:0]        drive_value;
    logic [MagW-1:0]        magnitude;
    logic signed [SumW-1:0] quad_phase;
    logic signed [SumW-1:0] in_phase;
  } result_t;

endpackage

// File: sv/qidd_mix.sv
// sign mixer, i/q integrators and frame counter
`timescale 1ns / 1ps

module qidd_mix (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  qidd_pkg::cfg_t                 cfg_i,
  input  logic                           accept_i,
  input  logic [qidd_pkg::SampleBits-1:0] sample_i,
  output qidd_pkg::frame_t               frame_o
);

  localparam logic [1:0] Phase0 = 2'd0;
  localparam logic [1:0] Phase1 = 2'd1;
  localparam logic [1:0] Phase3 = 2'd3;

  logic signed [qidd_pkg::SumW-1:0] i_sum_q, i_sum_d;
  logic signed [qidd_pkg::SumW-1:0] q_sum_q, q_sum_d;
  logic signed [qidd_pkg::SumW-1:0] i_next, q_next, t_ext;
  logic [1:0]                       phase_q, phase_d;
  logic [qidd_pkg::LenW-1:0]        count_q, count_d;
  logic [qidd_pkg::LenW:0]          count_next;
  logic                             i_add, q_add, group_end, frame_end;

  assign t_ext = $signed({{(qidd_pkg::SumW - qidd_pkg::SampleBits){1'b0}}, sample_i});

  always_comb begin
    if (cfg_i.quad) begin
      i_add     = (phase_q == Phase0) || (phase_q == Phase3);
      q_add     = (phase_q == Phase0) || (phase_q == Phase1);
      group_end = (phase_q == Phase3);
      q_next    = q_add ? q_sum_q + t_ext : q_sum_q - t_ext;
    end else begin
      i_add     = !phase_q[0];
      q_add     = 1'b0;
      group_end = phase_q[0];
      q_next    = q_sum_q;
    end
    i_next     = i_add ? i_sum_q + t_ext : i_sum_q - t_ext;
    count_next = {1'b0, count_q} + (cfg_i.quad ? (qidd_pkg::LenW+1)'(qidd_pkg::GroupQuad)
                                               : (qidd_pkg::LenW+1)'(qidd_pkg::GroupTwo));
    frame_end  = group_end && !(count_next < {1'b0, cfg_i.frame_len});
  end

  always_comb begin
    i_sum_d = i_sum_q;
    q_sum_d = q_sum_q;
    phase_d = phase_q;
    count_d = count_q;
    if (accept_i) begin
      phase_d = group_end ? Phase0 : phase_q + 2'd1;
      if (frame_end) begin
        i_sum_d = '0;
        q_sum_d = '0;
        count_d = '0;
      end else begin
        i_sum_d = i_next;
        q_sum_d = q_next;
        if (group_end) begin
          count_d = count_next[qidd_pkg::LenW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_sum_q <= '0;
      q_sum_q <= '0;
      phase_q <= Phase0;
      count_q <= '0;
    end else begin
      i_sum_q <= i_sum_d;
      q_sum_q <= q_sum_d;
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  assign frame_o.valid = accept_i && frame_end;
  assign frame_o.quad  = cfg_i.quad;
  assign frame_o.i_sum = i_next;
  assign frame_o.q_sum = q_next;

endmodule

// File: sv/qidd_mac.sv
// shared square-and-accumulate unit
`timescale 1ns / 1ps

module qidd_mac (
  input  logic signed [qidd_pkg::SqW-1:0]  a_i,
  input  logic        [qidd_pkg::AccW-1:0] acc_i,
  output logic        [qidd_pkg::AccW-1:0] res_o
);

  logic signed [qidd_pkg::AccW-1:0] sq;

  assign sq    = a_i * a_i;
  assign res_o = $unsigned(sq) + acc_i;

endmodule

// File: sv/qidd_seq.sv
// frame-end sequencer: energy, square-root estimate and drive value
`timescale 1ns / 1ps

module qidd_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qidd_pkg::cfg_t     cfg_i,
  input  qidd_pkg::frame_t   frame_i,
  input  logic               out_free_i,
  output logic               busy_o,
  output logic               done_o,
  output qidd_pkg::result_t  result_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSqI  = 3'd1;
  localparam logic [2:0] StSqQ  = 3'd2;
  localparam logic [2:0] StLoad = 3'd3;
  localparam logic [2:0] StNorm = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  logic [2:0]                        state_q, state_d;
  logic signed [qidd_pkg::SumW-1:0]  i_q, q_q;
  logic                              quad_q;
  logic [qidd_pkg::AccW-1:0]         acc_q, mac_res, mac_acc;
  logic signed [qidd_pkg::SqW-1:0]   mac_a;
  logic [qidd_pkg::EnW-1:0]          e_q, r_q, e_new;
  logic [qidd_pkg::HalfW-1:0]        h_q;
  logic [qidd_pkg::MagW-1:0]         mag_q;
  logic [qidd_pkg::DrvW-1:0]         drive_q, drive_new;
  logic [qidd_pkg::SumW-1:0]         i_abs;
  logic [qidd_pkg::EnW:0]            root_sum;
  logic signed [qidd_pkg::SumW-1:0]  i_shr;
  logic signed [qidd_pkg::SumW:0]    tv;

  assign mac_a   = (state_q == StSqQ) ? q_q[qidd_pkg::SumW-1:3] : i_q[qidd_pkg::SumW-1:3];
  assign mac_acc = (state_q == StSqQ) ? acc_q : '0;

  qidd_mac u_mac (
    .a_i   (mac_a),
    .acc_i (mac_acc),
    .res_o (mac_res)
  );

  always_comb begin
    i_abs = i_q[qidd_pkg::SumW-1] ? $unsigned(-i_q) : $unsigned(i_q);
    e_new = quad_q ? acc_q[qidd_pkg::AccW-1:8]
                   : {{(qidd_pkg::EnW - qidd_pkg::SumW + 2){1'b0}}, i_abs[qidd_pkg::SumW-1:2]};
    root_sum = ((qidd_pkg::EnW+1)'(1) << h_q) + {1'b0, e_q >> h_q};
  end

  always_comb begin
    i_shr = i_q >>> cfg_i.drive_shift;
    tv    = {i_shr[qidd_pkg::SumW-1], i_shr}
          + $signed({{(qidd_pkg::SumW - qidd_pkg::DrvW + 2){1'b0}},
                     cfg_i.pwm_top[qidd_pkg::DrvW-1:1]});
    if (cfg_i.pwm_top == '0 || tv[qidd_pkg::SumW]) begin
      drive_new = '0;
    end else if (tv >= $signed({{(qidd_pkg::SumW - qidd_pkg::DrvW + 1){1'b0}}, cfg_i.pwm_top}))
    begin
      drive_new = cfg_i.pwm_top - 1'b1;
    end else begin
      drive_new = tv[qidd_pkg::DrvW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (frame_i.valid) state_d = StSqI;
      StSqI:  state_d = StSqQ;
      StSqQ:  state_d = StLoad;
      StLoad: state_d = StNorm;
      StNorm: if (r_q[qidd_pkg::EnW-1:1] == '0) state_d = StFin;
      StFin:  state_d = StDone;
      StDone: if (out_free_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        i_q    <= frame_i.i_sum;
        q_q    <= frame_i.q_sum;
        quad_q <= frame_i.quad;
      end
      StSqI: begin
        acc_q   <= mac_res;
        drive_q <= drive_new;
      end
      StSqQ: acc_q <= mac_res;
      StLoad: begin
        e_q <= e_new;
        r_q <= e_new;
        h_q <= '0;
      end
      StNorm: begin
        if (r_q[qidd_pkg::EnW-1:1] != '0) begin
          r_q <= r_q >> 2;
          h_q <= h_q + 1'b1;
        end
      end
      StFin: mag_q <= (e_q == '0) ? '0 : root_sum[qidd_pkg::MagW:1];
      default: ;
    endcase
  end

  assign busy_o               = (state_q != StIdle);
  assign done_o               = (state_q == StDone);
  assign result_o.in_phase    = i_q;
  assign result_o.quad_phase  = q_q;
  assign result_o.magnitude   = mag_q;
  assign result_o.drive_value = drive_q;

endmodule

// File: sv/quadrature_integrate_dump_demod_top.sv
// top level: config registers, stream ports and output register
// a sample that does not end a frame leaves the input open, so the next sample may follow at once
// a frame-ending sample keeps the input stalled while the sequencer squares I and Q, loads the energy,
// runs the iterative square-root steps and finishes the result, and while an earlier result still waits
// the result shows on the output at the edge the input opens again and waits there
// rst_ni clears sums, phase, count and handshake state and restores register defaults
`timescale 1ns / 1ps

module quadrature_integrate_dump_demod_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [qidd_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [qidd_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [qidd_pkg::InTdataW-1:0]     s_axis_tdata,  // sample
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [qidd_pkg::OutTdataW-1:0]    m_axis_tdata   // in_phase, quad_phase, magnitude, drive_value
);

  qidd_pkg::cfg_t    cfg_q;
  qidd_pkg::frame_t  frame;
  qidd_pkg::result_t result, out_q;
  logic              out_valid_q, out_free, busy, done, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quad        <= 1'b0;
      cfg_q.frame_len   <= qidd_pkg::FrameLenRst;
      cfg_q.pwm_top     <= qidd_pkg::PwmTopRst;
      cfg_q.drive_shift <= qidd_pkg::DriveShiftRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        qidd_pkg::RegQuadMode:  cfg_q.quad        <= cfg_wdata_i[0];
        qidd_pkg::RegFrameLen:  cfg_q.frame_len   <= cfg_wdata_i[qidd_pkg::LenW-1:0];
        qidd_pkg::RegPwmTop:    cfg_q.pwm_top     <= cfg_wdata_i[qidd_pkg::DrvW-1:0];
        qidd_pkg::RegDriveShft: cfg_q.drive_shift <= cfg_wdata_i[qidd_pkg::ShiftW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  qidd_mix u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .sample_i (s_axis_tdata[qidd_pkg::SampleBits-1:0]),
    .frame_o  (frame)
  );

  qidd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .frame_i    (frame),
    .out_free_i (out_free),
    .busy_o     (busy),
    .done_o     (done),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && out_free) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(qidd_pkg::OutTdataW - qidd_pkg::OutFieldW){1'b0}}, out_q};

endmodule

// File: sv/qidd_checker.sv
// port-level checker for the demodulator, bound to the top level
`timescale 1ns / 1ps

module qidd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [qidd_pkg::OutTdataW-1:0] m_axis_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // a new result only appears at the end of a busy stretch
  a_rise_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready) && s_axis_tready)
    else $error("result appeared without a frame computation");

  // the frame-end computation does not release the input as soon as it stalls
  a_busy_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> ##1 !s_axis_tready ##1 !s_axis_tready)
    else $error("frame-end computation ended too early");

  // the input only stalls after a sample was taken
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("input stalled without an accepted sample");

endmodule

bind quadrature_integrate_dump_demod_top qidd_checker u_qidd_checker (.*);

// File: verif/qidd_frame_checker.sv
// frame result predictor and scoreboard for the quadrature integrate-and-dump demodulator
`timescale 1ns / 1ps

module qidd_frame_checker
  import qidd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgAddrW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // sample
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [OutTdataW-1:0] m_axis_tdata,   // in_phase, quad_phase, magnitude, drive_value
  output int                   pending_o,
  output int                   errors_o
);

  logic                   mode_quad;
  logic [LenW-1:0]        frame_len;
  logic [DrvW-1:0]        pwm_top;
  logic [ShiftW-1:0]      drive_shift;

  logic signed [SumW-1:0] i_acc;
  logic signed [SumW-1:0] q_acc;
  logic [1:0]             mix_phase;
  logic [LenW-1:0]        sample_cnt;

  result_t                frames_due[$];
  int                     mismatch_cnt;

  // accumulate one sample; returns 1 with the frame result when a frame closes
  function automatic bit fold_sample(input logic [SampleBits-1:0] smp, output result_t res);
    logic [LenW:0]     nxt;
    bit                grp_end;
    longint            iv;
    longint            qv;
    longint            ti;
    longint            tq;
    longint            tv;
    longint unsigned   energy;
    longint unsigned   seed;
    longint unsigned   root;
    longint unsigned   tmp;
    int                nb;
    logic [DrvW-1:0]   drv;
    res = '0;
    if (mode_quad) begin
      i_acc = (mix_phase == 2'd0 || mix_phase == 2'd3) ? i_acc + smp : i_acc - smp;
      q_acc = (mix_phase == 2'd0 || mix_phase == 2'd1) ? q_acc + smp : q_acc - smp;
      grp_end = (mix_phase == 2'd3);
    end else begin
      i_acc = mix_phase[0] ? i_acc - smp : i_acc + smp;
      grp_end = mix_phase[0];
    end
    if (!grp_end) begin
      mix_phase = mix_phase + 2'd1;
      return 1'b0;
    end
    mix_phase = 2'd0;
    nxt = {1'b0, sample_cnt} + (mode_quad ? (LenW+1)'(GroupQuad) : (LenW+1)'(GroupTwo));
    if (nxt < {1'b0, frame_len}) begin
      sample_cnt = nxt[LenW-1:0];
      return 1'b0;
    end

    iv = i_acc;
    qv = q_acc;
    if (mode_quad) begin
      ti = iv >>> 3;
      tq = qv >>> 3;
      energy = longint'(ti * ti + tq * tq) >> 8;
    end else begin
      energy = (iv < 0 ? -iv : iv) >> 2;
    end
    root = 0;
    if (energy != 0) begin
      nb = 0;
      tmp = energy;
      while (tmp != 0) begin
        tmp = tmp >> 1;
        nb++;
      end
      seed = 64'd1 << (nb / 2);
      root = (seed + energy / seed) / 2;
    end

    tv = (iv >>> drive_shift) + longint'(pwm_top >> 1);
    if (pwm_top == '0 || tv < 0) begin
      drv = '0;
    end else if (tv >= longint'(pwm_top)) begin
      drv = pwm_top - 1'b1;
    end else begin
      drv = tv[DrvW-1:0];
    end

    res.in_phase    = i_acc;
    res.quad_phase  = q_acc;
    res.magnitude   = root[MagW-1:0];
    res.drive_value = drv;
    i_acc = '0;
    q_acc = '0;
    sample_cnt = '0;
    return 1'b1;
  endfunction

  task automatic match_frame(input result_t got);
    result_t want;
    bool_check: begin
      if (frames_due.size() == 0) begin
        if (mismatch_cnt < 10) begin
          $display("%0t: unexpected result I %0d Q %0d mag %0d drive %0d", $realtime,
                   got.in_phase, got.quad_phase, got.magnitude, got.drive_value);
        end
        mismatch_cnt++;
      end else begin
        want = frames_due.pop_front();
        if (got.in_phase !== want.in_phase || got.quad_phase !== want.quad_phase ||
            got.magnitude !== want.magnitude || got.drive_value !== want.drive_value) begin
          if (mismatch_cnt < 10) begin
            $display("%0t: result mismatch exp I %0d Q %0d mag %0d drive %0d", $realtime,
                     want.in_phase, want.quad_phase, want.magnitude, want.drive_value);
            $display("%0t:                 got I %0d Q %0d mag %0d drive %0d", $realtime,
                     got.in_phase, got.quad_phase, got.magnitude, got.drive_value);
          end
          mismatch_cnt++;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t res;
    if (!rst_ni) begin
      mode_quad    = 1'b0;
      frame_len    = FrameLenRst;
      pwm_top      = PwmTopRst;
      drive_shift  = DriveShiftRst;
      i_acc        = '0;
      q_acc        = '0;
      mix_phase    = '0;
      sample_cnt   = '0;
      mismatch_cnt = 0;
      frames_due.delete();
      pending_o   <= 0;
      errors_o    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        match_frame(m_axis_tdata[OutFieldW-1:0]);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (fold_sample(s_axis_tdata[SampleBits-1:0], res)) begin
          frames_due.push_back(res);
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          RegQuadMode:  mode_quad   = cfg_wdata_i[0];
          RegFrameLen:  frame_len   = cfg_wdata_i[LenW-1:0];
          RegPwmTop:    pwm_top     = cfg_wdata_i[DrvW-1:0];
          RegDriveShft: drive_shift = cfg_wdata_i[ShiftW-1:0];
          default: ;
        endcase
      end
      pending_o <= frames_due.size();
      errors_o  <= mismatch_cnt;
    end
  end

endmodule

// File: verif/testbench.sv
// stimulus, clocking and verdict for the quadrature integrate-and-dump demodulator
`timescale 1ns / 1ps

module testbench;
  import qidd_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgAddrW-1:0]  cfg_addr_i;
  logic [CfgDataW-1:0]  cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;   // sample
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;   // in_phase, quad_phase, magnitude, drive_value

  int pending;
  int errors;
  bit sender_idle;
  bit sink_idle;

  quadrature_integrate_dump_demod_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  qidd_frame_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending_o     (pending),
    .errors_o      (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAIL quadrature_integrate_dump_demod_top");
    $finish;
  end

  // result sink with random stalls
  initial begin
    int n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      n = sink_idle ? $urandom_range(0, 9) : 0;
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  task automatic push_sample(input logic [SampleBits-1:0] smp);
    int n;
    n = sender_idle ? $urandom_range(0, 9) : 0;
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InTdataW'(smp);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop sending, wait for every frame result, then let the block go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic load_regs(input bit quad, input int len, input int top, input int shift);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= RegQuadMode;
    cfg_wdata_i <= CfgDataW'(quad);
    @(posedge clk_i);
    cfg_addr_i  <= RegFrameLen;
    cfg_wdata_i <= CfgDataW'(len);
    @(posedge clk_i);
    cfg_addr_i  <= RegPwmTop;
    cfg_wdata_i <= CfgDataW'(top);
    @(posedge clk_i);
    cfg_addr_i  <= RegDriveShft;
    cfg_wdata_i <= CfgDataW'(shift);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // tone styles put near-full scale on the phases selected by the pattern
  function automatic logic [SampleBits-1:0] make_sample(input int style, input logic [3:0] pat,
                                                        input int k);
    logic [SampleBits-1:0] smp;
    case (style)
      0: smp = SampleBits'($urandom_range(0, 1023));
      3: smp = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
      default: smp = pat[k % 4] ? SampleBits'($urandom_range(1000, 1023))
                                : SampleBits'($urandom_range(0, 23));
    endcase
    return smp;
  endfunction

  initial begin
    int sent;
    int n;
    int len;
    int top;
    int wait_cyc;
    bit quad;
    int style;
    logic [3:0] pat;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    sender_idle   = 1'b1;
    sink_idle     = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero energy frame, zero pwm top
    load_regs(1'b0, 2, 0, 0);
    push_sample(10'd0);
    push_sample(10'd0);
    push_sample(10'd1023);
    push_sample(10'd0);
    settle();

    // frame length below the group size, widest pwm top
    load_regs(1'b1, 0, 65535, 0);
    push_sample(10'd1023);
    push_sample(10'd0);
    push_sample(10'd0);
    push_sample(10'd1023);
    push_sample(10'd0);
    push_sample(10'd1023);
    push_sample(10'd1023);
    push_sample(10'd0);
    settle();

    // mode switches inside a group
    load_regs(1'b1, 2, 1, 31);
    push_sample(10'd500);
    push_sample(10'd300);
    settle();
    load_regs(1'b0, 2, 1, 31);
    push_sample(10'd7);
    push_sample(10'd1000);
    settle();
    push_sample(10'd5);
    settle();
    load_regs(1'b1, 4, 27, 3);
    push_sample(10'd9);
    push_sample(10'd400);
    push_sample(10'd1023);
    settle();

    sent = 0;
    while (sent < 1100) begin
      quad = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
        0: len = $urandom_range(0, 3);
        1: len = $urandom_range(100, 400);
        default: len = $urandom_range(4, 40);
      endcase
      case ($urandom_range(0, 5))
        0: top = 0;
        1: top = 1;
        2: top = 65535;
        default: top = $urandom_range(1, 65535);
      endcase
      style = $urandom_range(0, 3);
      pat = 4'($urandom_range(0, 15));
      settle();
      sender_idle = $urandom_range(0, 3) != 0;
      sink_idle   = $urandom_range(0, 3) != 0;
      load_regs(quad, len, top, $urandom_range(0, 31));
      n = $urandom_range(20, 80);
      for (int k = 0; k < n; k++) begin
        push_sample(make_sample(style, pat, k));
      end
      sent += n;
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait_cyc = 0;
    while (pending != 0 && wait_cyc < 5000) begin
      @(posedge clk_i);
      wait_cyc++;
    end
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("PASS quadrature_integrate_dump_demod_top");
    end else begin
      $display("FAIL quadrature_integrate_dump_demod_top");
    end
    $finish;
  end

endmodule
